### src/rrd_pkg.sv
`timescale 1ns / 1ps

package rrd_pkg;

   localparam int COS_FRAC = 24;
   localparam int RATIO_FRAC = 12;
   localparam int NORM_MSB = 29;
   localparam int COS_W = 28;

   localparam logic [15:0] RATIO_ENTERING_RESET = 16'd4551;
   localparam logic [15:0] RATIO_LEAVING_RESET = 16'd3686;

   localparam logic REG_RATIO_ENTERING = 1'b0;
   localparam logic REG_RATIO_LEAVING = 1'b1;

   typedef struct packed {
      logic en;
      logic valid;
   } flow_type;

endpackage

### src/rrd_sqrt.sv
`timescale 1ns / 1ps

module rrd_sqrt #(
   parameter int XW = 62,
   parameter int SW = 1,
   parameter int STEPS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  rrd_pkg::flow_type   in_flow,
   input  logic [XW-1:0]       in_x,
   input  logic [SW-1:0]       in_side,
   output logic                out_valid,
   output logic [XW/2-1:0]     out_root,
   output logic [SW-1:0]       out_side
);

   localparam int RW = XW / 2;
   localparam int NS = (RW + STEPS - 1) / STEPS;

   logic [XW-1:0] x_ff [NS];
   logic [RW+2:0] rem_ff [NS];
   logic [RW-1:0] root_ff [NS];
   logic [SW-1:0] side_ff [NS];
   logic          v_ff [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic [XW-1:0] x_src;
      logic [RW+2:0] rem_src;
      logic [RW-1:0] root_src;
      logic [SW-1:0] side_src;
      logic          v_src;
      logic [RW+2:0] rem_in;
      logic [RW-1:0] root_in;

      if (k == 0) begin : g_first
         assign x_src = in_x;
         assign rem_src = '0;
         assign root_src = '0;
         assign side_src = in_side;
         assign v_src = in_flow.valid;
      end else begin : g_next
         assign x_src = x_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign side_src = side_ff[k-1];
         assign v_src = v_ff[k-1];
      end

      always_comb begin
         logic [RW+2:0] trial;
         int idx;
         int pos;
         rem_in = rem_src;
         root_in = root_src;
         for (int j = 0; j < STEPS; j++) begin
            idx = k * STEPS + j;
            if (idx < RW) begin
               pos = RW - 1 - idx;
               rem_in = (rem_in << 2) | (RW+3)'(x_src[2*pos +: 2]);
               trial = ((RW+3)'(root_in) << 2) | (RW+3)'(1);
               if (rem_in >= trial) begin
                  rem_in = rem_in - trial;
                  root_in = (root_in << 1) | RW'(1);
               end else begin
                  root_in = root_in << 1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (in_flow.en) begin
            v_ff[k] <= v_src;
         end
         if (in_flow.en) begin
            x_ff[k] <= x_src;
            rem_ff[k] <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_root = root_ff[NS-1];
   assign out_side = side_ff[NS-1];

endmodule

### src/rrd_norm.sv
`timescale 1ns / 1ps

module rrd_norm #(
   parameter int IW = 16,
   parameter int CB = 16,
   parameter int SW = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rrd_pkg::flow_type    in_flow,
   input  logic signed [IW-1:0] in_vec [3],
   input  logic [SW-1:0]        in_side,
   output logic                 out_valid,
   output logic signed [CB-1:0] out_vec [3],
   output logic [SW-1:0]        out_side
);

   localparam int FRAC = CB - 2;
   localparam int MW = rrd_pkg::NORM_MSB + 1;
   localparam int SHW = $clog2(IW + MW);
   localparam int XW = 2 * MW + 2;
   localparam int RW = XW / 2;
   localparam int QSW = 3 * MW + 4 + SW;
   localparam int NQ = FRAC + 1;
   localparam int DS = 4;
   localparam int ND = (NQ + DS - 1) / DS;

   logic [IW-1:0]     mag1_ff [3];
   logic [2:0]        neg1_ff;
   logic [SW-1:0]     side1_ff;
   logic              v1_ff;

   logic [IW-1:0]     mag2_ff [3];
   logic [2:0]        neg2_ff;
   logic              zero2_ff;
   logic              left2_ff;
   logic [SHW-1:0]    amt2_ff;
   logic [SW-1:0]     side2_ff;
   logic              v2_ff;

   logic [MW-1:0]     sh3_ff [3];
   logic [2:0]        neg3_ff;
   logic              zero3_ff;
   logic [SW-1:0]     side3_ff;
   logic              v3_ff;

   logic [2*MW-1:0]   sq4_ff [3];
   logic [MW-1:0]     sh4_ff [3];
   logic [2:0]        neg4_ff;
   logic              zero4_ff;
   logic [SW-1:0]     side4_ff;
   logic              v4_ff;

   logic [XW-1:0]     ss5_ff;
   logic [QSW-1:0]    qside5_ff;
   logic              v5_ff;

   logic [IW-1:0]     mag_in [3];
   logic [IW-1:0]     max_in;
   logic [SHW-1:0]    msb_in;
   logic [MW-1:0]     sh_in [3];

   logic              sq_valid;
   logic [RW-1:0]     len;
   logic [QSW-1:0]    sq_side;

   logic [RW:0]       r_ff [ND][3];
   logic [FRAC:0]     q_ff [ND][3];
   logic [RW-1:0]     len_ff [ND];
   logic [2:0]        negd_ff [ND];
   logic              zerod_ff [ND];
   logic [SW-1:0]     sided_ff [ND];
   logic              vd_ff [ND];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = in_vec[i][IW-1] ? IW'(-in_vec[i]) : IW'(in_vec[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (in_flow.en) begin
         v1_ff <= in_flow.valid;
      end
      if (in_flow.en) begin
         for (int i = 0; i < 3; i++) begin
            mag1_ff[i] <= mag_in[i];
            neg1_ff[i] <= in_vec[i][IW-1];
         end
         side1_ff <= in_side;
      end
   end

   always_comb begin
      max_in = mag1_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (mag1_ff[i] > max_in) begin
            max_in = mag1_ff[i];
         end
      end
      msb_in = '0;
      for (int b = 0; b < IW; b++) begin
         if (max_in[b]) begin
            msb_in = SHW'(b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (in_flow.en) begin
         v2_ff <= v1_ff;
      end
      if (in_flow.en) begin
         mag2_ff <= mag1_ff;
         neg2_ff <= neg1_ff;
         zero2_ff <= (max_in == '0);
         left2_ff <= (msb_in < SHW'(rrd_pkg::NORM_MSB));
         amt2_ff <= (msb_in < SHW'(rrd_pkg::NORM_MSB)) ?
                    SHW'(rrd_pkg::NORM_MSB) - msb_in : msb_in - SHW'(rrd_pkg::NORM_MSB);
         side2_ff <= side1_ff;
      end
   end

   always_comb begin
      logic [IW+MW-1:0] ext;
      logic [IW+MW-1:0] moved;
      for (int i = 0; i < 3; i++) begin
         ext = (IW+MW)'(mag2_ff[i]);
         moved = left2_ff ? (ext << amt2_ff) : (ext >> amt2_ff);
         sh_in[i] = moved[MW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (in_flow.en) begin
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      if (in_flow.en) begin
         sh3_ff <= sh_in;
         neg3_ff <= neg2_ff;
         zero3_ff <= zero2_ff;
         side3_ff <= side2_ff;
         for (int i = 0; i < 3; i++) begin
            sq4_ff[i] <= sh3_ff[i] * sh3_ff[i];
         end
         sh4_ff <= sh3_ff;
         neg4_ff <= neg3_ff;
         zero4_ff <= zero3_ff;
         side4_ff <= side3_ff;
         ss5_ff <= XW'(sq4_ff[0]) + XW'(sq4_ff[1]) + XW'(sq4_ff[2]);
         qside5_ff <= {sh4_ff[2], sh4_ff[1], sh4_ff[0], neg4_ff, zero4_ff, side4_ff};
      end
   end

   rrd_sqrt #(
      .XW(XW),
      .SW(QSW),
      .STEPS(4)
   ) u_sqrt (
      .clock(clock),
      .reset(reset),
      .in_flow('{en: in_flow.en, valid: v5_ff}),
      .in_x(ss5_ff),
      .in_side(qside5_ff),
      .out_valid(sq_valid),
      .out_root(len),
      .out_side(sq_side)
   );

   for (genvar k = 0; k < ND; k++) begin : g_div
      logic [RW:0]   r_src [3];
      logic [FRAC:0] q_src [3];
      logic [RW-1:0] len_src;
      logic [2:0]    neg_src;
      logic          zero_src;
      logic [SW-1:0] side_src;
      logic          v_src;
      logic [RW:0]   r_in [3];
      logic [FRAC:0] q_in [3];

      if (k == 0) begin : g_first
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign r_src[i] = (RW+1)'(sq_side[SW+4+i*MW +: MW]);
            assign q_src[i] = '0;
         end
         assign len_src = len;
         assign neg_src = sq_side[SW+1 +: 3];
         assign zero_src = sq_side[SW];
         assign side_src = sq_side[SW-1:0];
         assign v_src = sq_valid;
      end else begin : g_next
         assign r_src = r_ff[k-1];
         assign q_src = q_ff[k-1];
         assign len_src = len_ff[k-1];
         assign neg_src = negd_ff[k-1];
         assign zero_src = zerod_ff[k-1];
         assign side_src = sided_ff[k-1];
         assign v_src = vd_ff[k-1];
      end

      always_comb begin
         int idx;
         for (int i = 0; i < 3; i++) begin
            r_in[i] = r_src[i];
            q_in[i] = q_src[i];
            for (int j = 0; j < DS; j++) begin
               idx = k * DS + j;
               if (idx < NQ) begin
                  if (idx != 0) begin
                     r_in[i] = r_in[i] << 1;
                  end
                  if (r_in[i] >= (RW+1)'(len_src)) begin
                     r_in[i] = r_in[i] - (RW+1)'(len_src);
                     q_in[i] = (q_in[i] << 1) | (FRAC+1)'(1);
                  end else begin
                     q_in[i] = q_in[i] << 1;
                  end
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[k] <= 1'b0;
         end else if (in_flow.en) begin
            vd_ff[k] <= v_src;
         end
         if (in_flow.en) begin
            r_ff[k] <= r_in;
            q_ff[k] <= q_in;
            len_ff[k] <= len_src;
            negd_ff[k] <= neg_src;
            zerod_ff[k] <= zero_src;
            sided_ff[k] <= side_src;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (zerod_ff[ND-1]) begin
            out_vec[i] = '0;
         end else if (negd_ff[ND-1][i]) begin
            out_vec[i] = -CB'(q_ff[ND-1][i]);
         end else begin
            out_vec[i] = CB'(q_ff[ND-1][i]);
         end
      end
   end

   assign out_valid = vd_ff[ND-1];
   assign out_side = sided_ff[ND-1];

endmodule

### src/ray_refract_reflect_direction.sv
`timescale 1ns / 1ps

// Refraction and reflection direction unit.
// The req_ channel takes one beat per ray: direction and surface normal, six signed
// Q1.(COMPONENT_BITS-2) components. The rsp_ channel returns one beat per ray: the
// unit scattered direction in tdata, and in tuser whether the ray refracted or was
// totally reflected and whether it was leaving the surface.
// The csr_ channel writes the two index ratios (Q4.12); it is always ready. The user
// must write it only while no ray is in flight; the block does not enforce this.
// At the default width of 16 bits the pipeline has 2 input stages, two
// normalizers of 17 stages each (5 scaling stages, an 8-stage square root and a
// divider that resolves 4 quotient bits per stage), 5 stages of cosine and
// discriminant work, an 8-stage square root of the discriminant and one product
// stage. The divider depth grows with COMPONENT_BITS.
// One beat is accepted every cycle while the receiver does not stall. When it stalls,
// the whole pipeline holds and req_tready falls in the same cycle; no beat is lost or repeated.
// Reset empties the pipeline and loads the default ratios.

module ray_refract_reflect_direction #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // dir_x, dir_y, dir_z, nrm_x, nrm_y, nrm_z, zero fill
   input  logic [((6*COMPONENT_BITS+7)/8)*8-1:0]  req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // out_x, out_y, out_z, zero fill
   output logic [((3*COMPONENT_BITS+7)/8)*8-1:0]  rsp_tdata,
   // refracted, leaving
   output logic [1:0]                             rsp_tuser,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic                                   csr_index,
   input  logic [15:0]                            csr_data
);

   localparam int CB = COMPONENT_BITS;
   localparam int FRAC = CB - 2;
   localparam int CW = rrd_pkg::COS_W;
   localparam int TW = CB + 15;
   localparam int TTW = CB + 30;
   localparam int VW = CB + 32;
   localparam int DOUT = ((3 * CB + 7) / 8) * 8;
   localparam int UN_RSH = (2 * FRAC >= rrd_pkg::COS_FRAC) ? 2 * FRAC - rrd_pkg::COS_FRAC : 0;
   localparam int UN_LSH = (2 * FRAC < rrd_pkg::COS_FRAC) ? rrd_pkg::COS_FRAC - 2 * FRAC : 0;
   localparam int SW1 = 3 * CB + 1;
   localparam int SW2 = 3 * TW + 3 * VW + 3 * (CB + 1) + 18;
   localparam logic signed [CB-1:0] UNIT_POS = CB'(1) << FRAC;
   localparam logic signed [CB-1:0] UNIT_NEG = -(CB'(1) << FRAC);

   logic                  en;
   rrd_pkg::flow_type     flow;

   logic [15:0]           ratio_entering_ff;
   logic [15:0]           ratio_leaving_ff;

   logic signed [CB-1:0]  d0_ff [3];
   logic signed [CB-1:0]  n0_ff [3];
   logic                  v0_ff;

   logic signed [CB-1:0]   d1_ff [3];
   logic signed [CB-1:0]   n1_ff [3];
   logic signed [2*CB-1:0] dn1_ff [3];
   logic                   v1_ff;
   logic signed [2*CB+1:0] dot1;
   logic                   leaving1;

   logic                  n1_valid;
   logic signed [CB-1:0]  u_n1 [3];
   logic [SW1-1:0]        side_n1;

   logic signed [CB-1:0]   u_p1_ff [3];
   logic signed [CB-1:0]   n_p1_ff [3];
   logic signed [2*CB-1:0] prod_p1_ff [3];
   logic                   lv_p1_ff;
   logic                   v_p1_ff;

   logic signed [2*CB+5:0] un_in;
   logic signed [CW-1:0]   un24_in;

   logic signed [CB-1:0]  u_p2_ff [3];
   logic signed [CB-1:0]  n_p2_ff [3];
   logic signed [CB:0]    nn_p2_ff [3];
   logic signed [CW-1:0]  un_p2_ff;
   logic signed [CW-1:0]  c_p2_ff;
   logic                  lv_p2_ff;
   logic                  v_p2_ff;

   logic signed [2*CW-1:0] csq_p3_ff;
   logic [31:0]            etasq_p3_ff;
   logic [15:0]            eta_p3_ff;
   logic signed [CB+28:0]  pa_p3_ff [3];
   logic signed [CB+27:0]  pr_p3_ff [3];
   logic signed [CB-1:0]   u_p3_ff [3];
   logic signed [CB:0]     nn_p3_ff [3];
   logic                   lv_p3_ff;
   logic                   v_p3_ff;

   logic signed [2*CW+1:0] kd_in;
   logic signed [TTW-1:0]  tt_in [3];

   logic signed [31:0]     k_p4_ff;
   logic signed [TW-1:0]   tfl_p4_ff [3];
   logic signed [VW-1:0]   refl_p4_ff [3];
   logic [31:0]            etasq_p4_ff;
   logic [15:0]            eta_p4_ff;
   logic signed [CB:0]     nn_p4_ff [3];
   logic                   lv_p4_ff;
   logic                   v_p4_ff;

   logic signed [63:0]     disc_p5_ff;
   logic signed [TW-1:0]   tfl_p5_ff [3];
   logic signed [VW-1:0]   refl_p5_ff [3];
   logic [15:0]            eta_p5_ff;
   logic signed [CB:0]     nn_p5_ff [3];
   logic                   lv_p5_ff;
   logic                   v_p5_ff;

   logic                   refr_p5;
   logic [61:0]            sq_x;
   logic [SW2-1:0]         sq_side_in;
   logic                   sq_valid;
   logic [30:0]            sq_root;
   logic [SW2-1:0]         sq_side;

   logic signed [TW-1:0]   tfl_s [3];
   logic signed [VW-1:0]   refl_s [3];
   logic signed [CB:0]     nn_s [3];
   logic [15:0]            eta_s;

   logic signed [VW-1:0]   a_q1_ff [3];
   logic signed [CB+32:0]  b_q1_ff [3];
   logic signed [VW-1:0]   refl_q1_ff [3];
   logic                   refr_q1_ff;
   logic                   lv_q1_ff;
   logic                   v_q1_ff;

   logic signed [VW-1:0]   v_in [3];
   logic signed [CB-1:0]   res [3];
   logic [1:0]             flags;

   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_entering_ff <= rrd_pkg::RATIO_ENTERING_RESET;
         ratio_leaving_ff <= rrd_pkg::RATIO_LEAVING_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            rrd_pkg::REG_RATIO_ENTERING: ratio_entering_ff <= csr_data;
            rrd_pkg::REG_RATIO_LEAVING:  ratio_leaving_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
         v1_ff <= v0_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            d0_ff[i] <= req_tdata[i*CB +: CB];
            n0_ff[i] <= req_tdata[(i+3)*CB +: CB];
            dn1_ff[i] <= d0_ff[i] * n0_ff[i];
         end
         d1_ff <= d0_ff;
         n1_ff <= n0_ff;
      end
   end

   assign dot1 = (2*CB+2)'(dn1_ff[0]) + (2*CB+2)'(dn1_ff[1]) + (2*CB+2)'(dn1_ff[2]);
   assign leaving1 = (dot1 > 0);
   assign flow = '{en: en, valid: v1_ff};

   rrd_norm #(
      .IW(CB),
      .CB(CB),
      .SW(SW1)
   ) u_norm_dir (
      .clock(clock),
      .reset(reset),
      .in_flow(flow),
      .in_vec(d1_ff),
      .in_side({n1_ff[2], n1_ff[1], n1_ff[0], leaving1}),
      .out_valid(n1_valid),
      .out_vec(u_n1),
      .out_side(side_n1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v_p1_ff <= 1'b0;
         v_p2_ff <= 1'b0;
         v_p3_ff <= 1'b0;
         v_p4_ff <= 1'b0;
         v_p5_ff <= 1'b0;
      end else if (en) begin
         v_p1_ff <= n1_valid;
         v_p2_ff <= v_p1_ff;
         v_p3_ff <= v_p2_ff;
         v_p4_ff <= v_p3_ff;
         v_p5_ff <= v_p4_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            n_p1_ff[i] <= side_n1[1+i*CB +: CB];
            prod_p1_ff[i] <= u_n1[i] * $signed(side_n1[1+i*CB +: CB]);
         end
         u_p1_ff <= u_n1;
         lv_p1_ff <= side_n1[0];
      end
   end

   always_comb begin
      un_in = (2*CB+6)'(prod_p1_ff[0]) + (2*CB+6)'(prod_p1_ff[1])
              + (2*CB+6)'(prod_p1_ff[2]);
      un24_in = CW'((un_in <<< UN_LSH) >>> UN_RSH);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_p2_ff <= u_p1_ff;
         n_p2_ff <= n_p1_ff;
         for (int i = 0; i < 3; i++) begin
            nn_p2_ff[i] <= lv_p1_ff ? -(CB+1)'(n_p1_ff[i]) : (CB+1)'(n_p1_ff[i]);
         end
         un_p2_ff <= un24_in;
         c_p2_ff <= lv_p1_ff ? -un24_in : un24_in;
         lv_p2_ff <= lv_p1_ff;

         csq_p3_ff <= c_p2_ff * c_p2_ff;
         eta_p3_ff <= lv_p2_ff ? ratio_leaving_ff : ratio_entering_ff;
         etasq_p3_ff <= lv_p2_ff ? ratio_leaving_ff * ratio_leaving_ff
                                 : ratio_entering_ff * ratio_entering_ff;
         for (int i = 0; i < 3; i++) begin
            pa_p3_ff[i] <= nn_p2_ff[i] * c_p2_ff;
            pr_p3_ff[i] <= n_p2_ff[i] * un_p2_ff;
         end
         u_p3_ff <= u_p2_ff;
         nn_p3_ff <= nn_p2_ff;
         lv_p3_ff <= lv_p2_ff;
      end
   end

   always_comb begin
      kd_in = ((2*CW+2)'(1) <<< 48) - (2*CW+2)'(csq_p3_ff);
      for (int i = 0; i < 3; i++) begin
         tt_in[i] = (TTW'(u_p3_ff[i]) <<< rrd_pkg::COS_FRAC) - TTW'(pa_p3_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k_p4_ff <= 32'(kd_in >>> rrd_pkg::COS_FRAC);
         for (int i = 0; i < 3; i++) begin
            tfl_p4_ff[i] <= TW'(tt_in[i] >>> rrd_pkg::RATIO_FRAC);
            refl_p4_ff[i] <= (VW'(u_p3_ff[i]) <<< rrd_pkg::COS_FRAC)
                             - (VW'(pr_p3_ff[i]) <<< 1);
         end
         etasq_p4_ff <= etasq_p3_ff;
         eta_p4_ff <= eta_p3_ff;
         nn_p4_ff <= nn_p3_ff;
         lv_p4_ff <= lv_p3_ff;

         disc_p5_ff <= (64'sd1 <<< 48) - $signed({1'b0, etasq_p4_ff}) * k_p4_ff;
         tfl_p5_ff <= tfl_p4_ff;
         refl_p5_ff <= refl_p4_ff;
         eta_p5_ff <= eta_p4_ff;
         nn_p5_ff <= nn_p4_ff;
         lv_p5_ff <= lv_p4_ff;
      end
   end

   assign refr_p5 = (disc_p5_ff > 0);
   assign sq_x = refr_p5 ? disc_p5_ff[61:0] : '0;
   assign sq_side_in = {tfl_p5_ff[2], tfl_p5_ff[1], tfl_p5_ff[0],
                        refl_p5_ff[2], refl_p5_ff[1], refl_p5_ff[0],
                        nn_p5_ff[2], nn_p5_ff[1], nn_p5_ff[0],
                        eta_p5_ff, refr_p5, lv_p5_ff};

   rrd_sqrt #(
      .XW(62),
      .SW(SW2),
      .STEPS(4)
   ) u_sqrt_disc (
      .clock(clock),
      .reset(reset),
      .in_flow('{en: en, valid: v_p5_ff}),
      .in_x(sq_x),
      .in_side(sq_side_in),
      .out_valid(sq_valid),
      .out_root(sq_root),
      .out_side(sq_side)
   );

   always_comb begin
      eta_s = sq_side[2 +: 16];
      for (int i = 0; i < 3; i++) begin
         nn_s[i] = sq_side[18 + i*(CB+1) +: CB+1];
         refl_s[i] = sq_side[18 + 3*(CB+1) + i*VW +: VW];
         tfl_s[i] = sq_side[18 + 3*(CB+1) + 3*VW + i*TW +: TW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_q1_ff <= 1'b0;
      end else if (en) begin
         v_q1_ff <= sq_valid;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            a_q1_ff[i] <= tfl_s[i] * $signed({1'b0, eta_s});
            b_q1_ff[i] <= nn_s[i] * $signed({1'b0, sq_root});
         end
         refl_q1_ff <= refl_s;
         refr_q1_ff <= sq_side[1];
         lv_q1_ff <= sq_side[0];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         v_in[i] = refr_q1_ff ? VW'((CB+33)'(a_q1_ff[i]) - b_q1_ff[i]) : refl_q1_ff[i];
      end
   end

   rrd_norm #(
      .IW(VW),
      .CB(CB),
      .SW(2)
   ) u_norm_out (
      .clock(clock),
      .reset(reset),
      .in_flow('{en: en, valid: v_q1_ff}),
      .in_vec(v_in),
      .in_side({lv_q1_ff, refr_q1_ff}),
      .out_valid(rsp_tvalid),
      .out_vec(res),
      .out_side(flags)
   );

   assign rsp_tdata = DOUT'({res[2], res[1], res[0]});
   assign rsp_tuser = flags;

   a_ready_follows_stall: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow the output stall");

   a_ratio_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_index == rrd_pkg::REG_RATIO_ENTERING |=>
      ratio_entering_ff == $past(csr_data))
      else $error("entering ratio write lost");

   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> res[0] <= UNIT_POS && res[0] >= UNIT_NEG
                  && res[1] <= UNIT_POS && res[1] >= UNIT_NEG
                  && res[2] <= UNIT_POS && res[2] >= UNIT_NEG)
      else $error("result component exceeds unit length");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

endmodule
